@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_W     = 5;
	localparam int INDEX_W     = $clog2(CAPACITY);
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_PUSH     = 2'd0,
		OP_POP      = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]             opcode;
		logic [VALUE_WIDTH-1:0] value;
	} item_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] popped_value;
		logic                   found;
		logic [1:0]             status;
		logic [COUNT_W-1:0]     entry_count;
		logic [VALUE_WIDTH-1:0] top_value;
		logic [VALUE_WIDTH-1:0] bottom_value;
		logic                   is_empty;
	} result_t;

	// decoded command handed from front to back
	typedef struct packed {
		logic                   is_push;
		logic                   is_pop;
		logic                   is_contains;
		logic                   is_clear;
		logic [VALUE_WIDTH-1:0] value;
	} cmd_t;

endpackage

@@ hw/rtl/spq_fifo.sv @@
// ----------------------------------------------------------------------------
// spq_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module spq_fifo
	import spq_pkg::*;
#(
	parameter type T     = logic,
	parameter int  DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  T     wdata,
	input  logic pop,
	output logic empty,
	output T     rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/spq_front.sv @@
// ----------------------------------------------------------------------------
// spq_front
// Accepts input items, decodes the opcode and queues commands for the back.
// ----------------------------------------------------------------------------
module spq_front
	import spq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	output logic  cmd_valid,
	input  logic  cmd_take,
	output cmd_t  cmd
);

	cmd_t dec;
	logic cmd_empty;

	always_comb begin
		dec             = '0;
		dec.value       = item.value;
		unique case (op_t'(item.opcode))
			OP_PUSH:     dec.is_push     = 1'b1;
			OP_POP:      dec.is_pop      = 1'b1;
			OP_CONTAINS: dec.is_contains = 1'b1;
			OP_CLEAR:    dec.is_clear    = 1'b1;
			default:     dec.is_clear    = 1'b1;
		endcase
	end

	spq_fifo #(
		.T     (cmd_t),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (dec),
		.pop    (cmd_take),
		.empty  (cmd_empty),
		.rdata  (cmd)
	);

	assign cmd_valid = !cmd_empty;

endmodule

@@ hw/rtl/spq_back.sv @@
// ----------------------------------------------------------------------------
// spq_back
// Sorted entry cells with parallel compare-and-shift, plus a report stage
// that forms the result from the updated entries.
// ----------------------------------------------------------------------------
module spq_back
	import spq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_take,
	input  cmd_t    cmd,
	output logic    res_push,
	input  logic    res_full,
	output result_t res
);

	logic [VALUE_WIDTH-1:0] entries_q [CAPACITY];
	logic [VALUE_WIDTH-1:0] entries_d [CAPACITY];
	logic [COUNT_W-1:0]     count_q;
	logic [COUNT_W-1:0]     count_d;
	logic [CAPACITY-1:0]    gt;
	logic [CAPACITY-1:0]    eq;
	logic                   push_ok;
	logic                   pop_ok;
	logic                   exec;

	logic                   pend_s1;
	logic [VALUE_WIDTH-1:0] popped_s1;
	logic                   found_s1;
	status_t                status_s1;
	logic [INDEX_W-1:0]     last_idx;

	// report stage drains into the result queue; execute may overlap it
	assign res_push = pend_s1 && !res_full;
	assign exec     = cmd_valid && (!pend_s1 || !res_full);
	assign cmd_take = exec;

	assign push_ok = cmd.is_push && (count_q != COUNT_W'(CAPACITY));
	assign pop_ok  = cmd.is_pop && (count_q != '0);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (COUNT_W'(i) < count_q) && (entries_q[i] > cmd.value);
			eq[i] = (COUNT_W'(i) < count_q) && (entries_q[i] == cmd.value);
		end
	end

	// each cell keeps, takes the new value, or shifts from a neighbor
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			entries_d[i] = entries_q[i];
		end
		if (push_ok) begin
			if (!gt[0]) begin
				entries_d[0] = cmd.value;
			end
			for (int i = 1; i < CAPACITY; i++) begin
				if (gt[i]) begin
					entries_d[i] = entries_q[i];
				end else if (gt[i-1]) begin
					entries_d[i] = cmd.value;
				end else begin
					entries_d[i] = entries_q[i-1];
				end
			end
		end else if (pop_ok) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				entries_d[i] = entries_q[i+1];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.is_clear) begin
			count_d = '0;
		end else if (push_ok) begin
			count_d = count_q + 1'b1;
		end else if (pop_ok) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			for (int i = 0; i < CAPACITY; i++) begin
				entries_q[i] <= entries_d[i];
			end
			popped_s1 <= pop_ok ? entries_q[0] : '0;
			found_s1  <= cmd.is_contains && (|eq);
			if (cmd.is_push && !push_ok) begin
				status_s1 <= ST_FULL;
			end else if (cmd.is_pop && !pop_ok) begin
				status_s1 <= ST_EMPTY;
			end else begin
				status_s1 <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (exec) begin
				count_q <= count_d;
				pend_s1 <= 1'b1;
			end else if (res_push) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	assign last_idx = INDEX_W'(count_q - 1'b1);

	always_comb begin
		res.popped_value = popped_s1;
		res.found        = found_s1;
		res.status       = status_s1;
		res.entry_count  = count_q;
		res.is_empty     = (count_q == '0);
		res.top_value    = (count_q == '0) ? '0 : entries_q[0];
		res.bottom_value = (count_q == '0) ? '0 : entries_q[last_idx];
	end

endmodule

@@ hw/rtl/sorted_priority_queue_top.sv @@
// Each input item passes the command queue, back end and result queue before its
// result shows on the ports. Throughput: one item per cycle while the result
// queue has room, set by the compare-and-shift across all back-end entry cells.
// Reset clears the entry count and both queues; entry cells are not cleared
// and are only read below the count.
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Max-priority queue kept sorted in descending order, queue-style ports.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
	import spq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_take;
	logic    res_push;
	logic    res_full;
	result_t res;

	spq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	spq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.res_push  (res_push),
		.res_full  (res_full),
		.res       (res)
	);

	spq_fifo #(
		.T     (result_t),
		.DEPTH (QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res),
		.pop    (pop),
		.empty  (empty),
		.rdata  (result)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.entry_count <= COUNT_W'(CAPACITY)))
		else $error("entry count beyond capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.is_empty == (result.entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status == ST_FULL)) |->
		(result.entry_count == COUNT_W'(CAPACITY)))
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status == ST_EMPTY)) |->
		(result.is_empty && (result.popped_value == '0)))
		else $error("empty status on a non-empty queue");

	a_found_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.found) |-> !result.is_empty)
		else $error("value found in an empty queue");

endmodule

@@ tb/sv/spq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches both queue-style channels of the sorted priority queue. For every
// input transfer it works out the expected result on its own copy of the
// sorted entries. It compares each result transfer, field by field, with the
// oldest expected result. It hands the mismatch count and the number of
// results still due back to the testbench top.
// ----------------------------------------------------------------------------
module spq_checker
	import spq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  item_t   item,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      errors,
	output int      outstanding
);

	logic [VALUE_WIDTH-1:0] entries [CAPACITY];
	int                     held;
	result_t                expected_results [$];

	// updates the local copy of the queue and returns the result it implies
	function automatic result_t predict_result(item_t it);
		result_t r;
		int      pos;
		r = '0;
		r.status = ST_OK;
		case (op_t'(it.opcode))
			OP_PUSH: begin
				if (held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < held && entries[pos] > it.value)
						pos++;
					for (int i = held; i > pos; i--)
						entries[i] = entries[i-1];
					entries[pos] = it.value;
					held++;
				end
			end
			OP_POP: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_value = entries[0];
					for (int i = 0; i + 1 < held; i++)
						entries[i] = entries[i+1];
					held--;
				end
			end
			OP_CONTAINS: begin
				for (int i = 0; i < held; i++)
					if (entries[i] == it.value)
						r.found = 1'b1;
			end
			default: begin
				held = 0;
			end
		endcase
		r.entry_count = held[COUNT_W-1:0];
		if (held == 0) begin
			r.is_empty = 1'b1;
		end else begin
			r.top_value    = entries[0];
			r.bottom_value = entries[held-1];
		end
		return r;
	endfunction

	task automatic compare_field(string name, logic [VALUE_WIDTH-1:0] exp_v,
			logic [VALUE_WIDTH-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			held = 0;
			errors = 0;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (push && !full)
				expected_results.push_back(predict_result(item));
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result transfer, expected none, actual %h",
						$time, result);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					compare_field("popped_value", exp_r.popped_value, result.popped_value);
					compare_field("found", VALUE_WIDTH'(exp_r.found),
						VALUE_WIDTH'(result.found));
					compare_field("status", VALUE_WIDTH'(exp_r.status),
						VALUE_WIDTH'(result.status));
					compare_field("entry_count", VALUE_WIDTH'(exp_r.entry_count),
						VALUE_WIDTH'(result.entry_count));
					compare_field("top_value", exp_r.top_value, result.top_value);
					compare_field("bottom_value", exp_r.bottom_value, result.bottom_value);
					compare_field("is_empty", VALUE_WIDTH'(exp_r.is_empty),
						VALUE_WIDTH'(result.is_empty));
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sorted priority queue with a directed opening (empty pop, clear
// and lookup, extreme values, duplicates, overflow of a full queue) and then
// random fill, drain and mixed phases with bursty idling on both sides. The
// checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import spq_pkg::*;

	localparam int RANDOM_ITEMS = 1050;
	localparam int CALM_TAIL    = 150;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    push   = 1'b0;
	item_t   item   = '0;
	logic    pop    = 1'b0;
	logic    full;
	logic    empty;
	result_t result;

	int errors;
	int outstanding;
	int quiet_cycles = 0;
	int pop_stall    = 0;
	bit idle_on      = 1'b1;

	logic [VALUE_WIDTH-1:0] pushed_values [$];

	sorted_priority_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	spq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: ready most of the time, with random stall bursts
	always @(negedge clk) begin
		if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall <= pop_stall - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			pop <= 1'b0;
			pop_stall <= $urandom_range(0, 10);
		end else begin
			pop <= 1'b1;
		end
	end

	// cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("testbench failed");
		$finish;
	end

	function automatic item_t make_item(op_t op, logic [VALUE_WIDTH-1:0] v);
		item_t it;
		it.opcode = op;
		it.value  = v;
		return it;
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_value(bit for_lookup);
		if (for_lookup && pushed_values.size() > 0 && $urandom_range(0, 1) == 0)
			return pushed_values[$urandom_range(0, pushed_values.size() - 1)];
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom_range(0, 15);
			4:       return 32'h8000_0000 | $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	// holds push high until the item transfers; push stays high afterwards
	task automatic send_item(item_t it);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (op_t'(it.opcode) == OP_PUSH) begin
			pushed_values.push_back(it.value);
			if (pushed_values.size() > 32)
				void'(pushed_values.pop_front());
		end
		@(negedge clk);
	endtask

	initial begin
		phase_t kind;
		int     sent;
		int     run_len;
		int     roll;
		op_t    op;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue corner cases
		send_item(make_item(OP_POP, '1));
		send_item(make_item(OP_CLEAR, '1));
		send_item(make_item(OP_CONTAINS, '0));
		// extremes and duplicates
		send_item(make_item(OP_PUSH, '0));
		send_item(make_item(OP_PUSH, '1));
		send_item(make_item(OP_PUSH, '1));
		send_item(make_item(OP_CONTAINS, '0));
		send_item(make_item(OP_CONTAINS, '1));
		send_item(make_item(OP_CONTAINS, 32'h7FFF_FFFF));
		send_item(make_item(OP_POP, '0));
		send_item(make_item(OP_CLEAR, '0));
		// fill past capacity so the last push is dropped
		for (int i = 0; i <= CAPACITY; i++)
			send_item(make_item(OP_PUSH, (i % 2) ? 32'h5555_5555 ^ i : 32'hAAAA_AAAA ^ i));

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			kind    = phase_t'($urandom_range(0, 2));
			run_len = $urandom_range(10, 60);
			for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
				idle_on = (sent < RANDOM_ITEMS - CALM_TAIL);
				roll = $urandom_range(0, 99);
				case (kind)
					PH_FILL:  op = (roll < 75) ? OP_PUSH : (roll < 85) ? OP_POP :
						(roll < 97) ? OP_CONTAINS : OP_CLEAR;
					PH_DRAIN: op = (roll < 20) ? OP_PUSH : (roll < 80) ? OP_POP :
						(roll < 97) ? OP_CONTAINS : OP_CLEAR;
					default:  op = (roll < 40) ? OP_PUSH : (roll < 70) ? OP_POP :
						(roll < 96) ? OP_CONTAINS : OP_CLEAR;
				endcase
				send_item(make_item(op, pick_value(op == OP_CONTAINS)));
				sent++;
			end
		end
		idle_on = 1'b0;
		push <= 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
